// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg
// Types, constants and the CRC-32 byte update for the command frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

    localparam int unsigned HDR_LEN    = 20;
    localparam int unsigned MIN_FRAME  = 24;
    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [31:0] START_CODE_RST = 32'h0000_0000;
    localparam logic [20:0] MAX_LEN_RST    = 21'd1024;

    localparam logic CFG_START_CODE = 1'b0;
    localparam logic CFG_MAX_LEN    = 1'b1;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STATUS  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_START = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_BAD_CRC   = 3'd4
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  version;
        logic [7:0]  flag_bits;
        logic [7:0]  frame_type;
        logic [15:0] command_id;
        logic [47:0] reply_pipe_id;
        logic [7:0]  sequence_res;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        status_t     status;
        logic        end_of_frame;
    } result_t;

    // Up to two results per transaction; r0 goes out first
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } res_push_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/command_frame_deframer.sv =====
// A byte is held in the input register, its first result in the result queue.
// Throughput: one byte per cycle unless stalled; a buffer's last byte may add a
// status result, so a result queue of FIFO_DEPTH entries absorbs the second result
// per byte. Input stall rises only when the queue holds fewer than two free entries.
// Reset: asynchronous, active low; clears frame state, queue and config to defaults.
// ----------------------------------------------------------------------------
// command_frame_deframer
// Byte-serial command frame parser with header, payload pass-through and CRC-32.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_deframer #(
    parameter int unsigned FIFO_DEPTH = cfd_pkg::FIFO_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        buffer_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       version,
    output logic [7:0]       flag_bits,
    output logic [7:0]       frame_type,
    output logic [15:0]      command_id,
    output logic [47:0]      reply_pipe_id,
    output logic [7:0]       sequence_res,
    output logic [31:0]      payload_length,
    output logic [7:0]       payload_byte,
    output logic [2:0]       status,
    output logic             end_of_frame
);

    cfd_pkg::res_push_t push;
    cfd_pkg::result_t   head;
    logic               room;

    cfd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .buffer_end   (buffer_end),
        .room         (room),
        .push         (push)
    );

    cfd_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind           = head.kind;
    assign version        = head.version;
    assign flag_bits      = head.flag_bits;
    assign frame_type     = head.frame_type;
    assign command_id     = head.command_id;
    assign reply_pipe_id  = head.reply_pipe_id;
    assign sequence_res   = head.sequence_res;
    assign payload_length = head.payload_length;
    assign payload_byte   = head.payload_byte;
    assign status         = head.status;
    assign end_of_frame   = head.end_of_frame;

endmodule

`default_nettype wire

// ===== rtl/cfd_parser.sv =====
// ----------------------------------------------------------------------------
// cfd_parser
// Input register, frame field capture, CRC update and result generation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cfd_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_en,
    input  wire logic              cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              buffer_end,
    input  wire logic              room,
    output cfd_pkg::res_push_t     push
);

    logic [31:0] start_code_reg;
    logic [20:0] max_len_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    logic [31:0] byte_count_reg, byte_count_next;
    logic [31:0] start_bytes_reg, start_bytes_next;
    logic [39:0] small_reg, small_next;
    logic [47:0] pipe_reg, pipe_next;
    logic [7:0]  seq_reg, seq_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] crc_rx_reg, crc_rx_next;

    logic        fire;
    logic [31:0] p;
    logic [32:0] end_pay;
    logic        in_hdr;
    logic        len_ok;
    logic [2:0]  idx_small;
    logic [2:0]  idx_pipe;
    logic [1:0]  idx_crc;
    cfd_pkg::result_t  main_res;
    cfd_pkg::result_t  stat_res;
    logic              main_vld;

    assign in_stall = s1_valid_reg && !room;
    assign fire     = s1_valid_reg && room;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start_code_reg <= cfd_pkg::START_CODE_RST;
            max_len_reg    <= cfd_pkg::MAX_LEN_RST;
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                cfd_pkg::CFG_START_CODE: start_code_reg <= cfg_data;
                cfd_pkg::CFG_MAX_LEN:    max_len_reg    <= cfg_data[20:0];
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && !in_stall) begin
            s1_byte_reg <= rx_byte;
            s1_last_reg <= buffer_end;
        end
    end

    always_comb begin
        p         = byte_count_reg;
        end_pay   = 33'(cfd_pkg::HDR_LEN) + {1'b0, length_reg};
        in_hdr    = p < 32'(cfd_pkg::HDR_LEN);
        len_ok    = length_reg <= {11'd0, max_len_reg};
        idx_small = 3'(p - 32'd4);
        idx_pipe  = 3'(p - 32'd9);
        idx_crc   = 2'(p[1:0] - end_pay[1:0]);

        byte_count_next  = (p == 32'hFFFF_FFFF) ? p : p + 32'd1;
        start_bytes_next = start_bytes_reg;
        small_next       = small_reg;
        pipe_next        = pipe_reg;
        seq_next         = seq_reg;
        length_next      = length_reg;
        crc_rx_next      = crc_rx_reg;
        crc_next         = crc_reg;

        main_res = '0;
        stat_res = '0;
        main_vld = 1'b0;

        if (p < 32'd4) begin
            start_bytes_next[{p[1:0], 3'b000} +: 8] = s1_byte_reg;
        end else if (p < 32'd9) begin
            small_next[{idx_small, 3'b000} +: 8] = s1_byte_reg;
        end else if (p < 32'd15) begin
            pipe_next[{idx_pipe, 3'b000} +: 8] = s1_byte_reg;
        end else if (p == 32'd15) begin
            seq_next = s1_byte_reg;
        end else if (in_hdr) begin
            length_next[{p[1:0], 3'b000} +: 8] = s1_byte_reg;
            if (p == 32'(cfd_pkg::HDR_LEN - 1)) begin
                main_vld                = 1'b1;
                main_res.kind           = cfd_pkg::KIND_HEADER;
                main_res.version        = small_reg[7:0];
                main_res.flag_bits      = small_reg[15:8];
                main_res.frame_type     = small_reg[23:16];
                main_res.command_id     = small_reg[39:24];
                main_res.reply_pipe_id  = pipe_reg;
                main_res.sequence_res   = seq_reg;
                main_res.payload_length = length_next;
            end
        end else if ({1'b0, p} < end_pay) begin
            if (len_ok) begin
                main_vld              = 1'b1;
                main_res.kind         = cfd_pkg::KIND_PAYLOAD;
                main_res.payload_byte = s1_byte_reg;
            end
        end else if ({2'b00, p} < ({1'b0, end_pay} + 34'd4)) begin
            crc_rx_next[{idx_crc, 3'b000} +: 8] = s1_byte_reg;
        end

        if ({1'b0, p} < end_pay) begin
            crc_next = cfd_pkg::crc_byte(crc_reg, s1_byte_reg);
        end

        stat_res.kind         = cfd_pkg::KIND_STATUS;
        stat_res.end_of_frame = 1'b1;
        if (byte_count_next < 32'(cfd_pkg::MIN_FRAME)) begin
            stat_res.status = cfd_pkg::ST_SHORT;
        end else if (start_bytes_next != start_code_reg) begin
            stat_res.status = cfd_pkg::ST_BAD_START;
        end else if (!len_ok || ({1'b0, byte_count_next} <
                     (33'(cfd_pkg::MIN_FRAME) + {1'b0, length_next}))) begin
            stat_res.status = cfd_pkg::ST_BAD_LEN;
        end else if (~crc_next != crc_rx_next) begin
            stat_res.status = cfd_pkg::ST_BAD_CRC;
        end else begin
            stat_res.status = cfd_pkg::ST_OK;
        end

        push = '0;
        if (fire) begin
            if (main_vld) begin
                push.r0 = main_res;
                push.r1 = stat_res;
                push.cnt = s1_last_reg ? 2'd2 : 2'd1;
            end else begin
                push.r0 = stat_res;
                push.cnt = s1_last_reg ? 2'd1 : 2'd0;
            end
        end

        // End of buffer: back to an empty frame
        if (s1_last_reg) begin
            byte_count_next  = '0;
            start_bytes_next = '0;
            small_next       = '0;
            pipe_next        = '0;
            seq_next         = '0;
            length_next      = '0;
            crc_next         = cfd_pkg::CRC_INIT;
            crc_rx_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            byte_count_reg  <= '0;
            start_bytes_reg <= '0;
            small_reg       <= '0;
            pipe_reg        <= '0;
            seq_reg         <= '0;
            length_reg      <= '0;
            crc_reg         <= cfd_pkg::CRC_INIT;
            crc_rx_reg      <= '0;
        end else if (fire) begin
            byte_count_reg  <= byte_count_next;
            start_bytes_reg <= start_bytes_next;
            small_reg       <= small_next;
            pipe_reg        <= pipe_next;
            seq_reg         <= seq_next;
            length_reg      <= length_next;
            crc_reg         <= crc_next;
            crc_rx_reg      <= crc_rx_next;
        end
    end

    `ASSERT_CLK(a_sat_no_wrap, (byte_count_reg == 32'hFFFF_FFFF) |=> (byte_count_reg == 32'hFFFF_FFFF || byte_count_reg == 32'd0), "byte count wrapped")
    `ASSERT_CLK(a_two_ends_in_status, (push.cnt == 2'd2) |-> (push.r1.kind == cfd_pkg::KIND_STATUS && push.r0.kind != cfd_pkg::KIND_STATUS), "bad result order")
    `ASSERT_CLK(a_header_pos, (push.cnt != 2'd0 && push.r0.kind == cfd_pkg::KIND_HEADER) |-> (byte_count_reg == 32'(cfd_pkg::HDR_LEN - 1)), "header at wrong position")
    `ASSERT_CLK(a_clear_after_end, (fire && s1_last_reg) |=> (byte_count_reg == 32'd0 && crc_reg == cfd_pkg::CRC_INIT), "frame state not cleared")

endmodule

`default_nettype wire

// ===== rtl/cfd_result_fifo.sv =====
// ----------------------------------------------------------------------------
// cfd_result_fifo
// Small result queue: takes up to two results a cycle, gives one if unstalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cfd_result_fifo #(
    parameter int unsigned DEPTH = cfd_pkg::FIFO_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfd_pkg::res_push_t push,
    output logic                    room,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output cfd_pkg::result_t        head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cfd_pkg::result_t ent_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    wr_ptr_p1;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             pop;

    function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] ptr);
        return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
    endfunction

    assign out_valid = count_reg != '0;
    assign head      = ent_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign room      = count_reg <= CW'(DEPTH - 2);
    assign wr_ptr_p1 = inc_ptr(wr_ptr_reg);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        case (push.cnt)
            2'd1:    wr_ptr_next = wr_ptr_p1;
            2'd2:    wr_ptr_next = inc_ptr(wr_ptr_p1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? inc_ptr(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push.cnt != 2'd0) begin
            ent_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            ent_reg[wr_ptr_p1] <= push.r1;
        end
    end

    `ASSERT_CLK(a_no_overflow, (push.cnt != 2'd0) |-> (count_reg <= CW'(DEPTH - 2)), "overflow")
    `ASSERT_CLK(a_count_range, count_reg <= CW'(DEPTH), "result count out of range")
    `ASSERT_ALWAYS(a_empty_in_reset, !rst_n |=> !out_valid, "valid after reset")

endmodule

`default_nettype wire
